>>> rtl/pmq_pkg.sv
`default_nettype none
package pmq_pkg;

   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned COUNT_MAX = 8191;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_RELEASE = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_ENQ,
      CMD_DEQ,
      CMD_REL,
      CMD_BAD
   } cmd_kind_type;

   typedef enum logic {
      PH_ISSUE,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] job_function;
      logic [63:0] job_argument;
      logic [2:0]  priority_req;
      logic [11:0] slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] out_function;
      logic [63:0] out_argument;
      logic [11:0] out_slot;
      logic [12:0] queued_count;
      logic [12:0] active_count;
      logic        drained;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [63:0]  job_function;
      logic [63:0]  job_argument;
      logic [2:0]   lane;
      logic [11:0]  slot;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/pmq_ram.sv
`default_nettype none
module pmq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/pmq_front.sv
`default_nettype none
module pmq_front #(
   parameter int unsigned POOL_SLOTS = 4096,
   parameter int unsigned LANES      = 4
) (
   input  wire logic             start,
   input  wire logic             full,
   input  wire pmq_pkg::req_type req_data,
   output logic                  push,
   output pmq_pkg::cmd_type      cmd
);
   import pmq_pkg::*;

   logic bad_enq;
   logic bad_rel;

   assign push    = start && !full;
   assign bad_enq = (req_data.job_function == 64'd0) ||
                    ({1'b0, req_data.priority_req} >= 4'(LANES));
   assign bad_rel = {5'd0, req_data.slot} >= 17'(POOL_SLOTS);

   always_comb begin
      cmd.job_function = req_data.job_function;
      cmd.job_argument = req_data.job_argument;
      cmd.lane         = req_data.priority_req;
      cmd.slot         = req_data.slot;
      case (req_data.opcode)
         OP_ENQUEUE: cmd.kind = bad_enq ? CMD_BAD : CMD_ENQ;
         OP_DEQUEUE: cmd.kind = CMD_DEQ;
         OP_RELEASE: cmd.kind = bad_rel ? CMD_BAD : CMD_REL;
         default:    cmd.kind = CMD_BAD;
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/pmq_fifo.sv
`default_nettype none
module pmq_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pmq_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output pmq_pkg::cmd_type      head_cmd
);
   import pmq_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

>>> rtl/pmq_back.sv
`default_nettype none
module pmq_back #(
   parameter int unsigned POOL_SLOTS = 4096,
   parameter int unsigned LANES      = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire pmq_pkg::cmd_type cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   output pmq_pkg::rsp_type      rsp_data
);
   import pmq_pkg::*;

   localparam int unsigned SW = $clog2(POOL_SLOTS);
   localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam logic [SW:0] POOL_N = (SW+1)'(POOL_SLOTS);

   phase_type          phase_ff, phase_in;
   cmd_type            cmd_ff, cmd_in;
   logic [SW:0]        depth_ff, depth_in;
   logic [SW:0]        low_ff, low_in;
   logic [SW-1:0]      head_ff [LANES];
   logic [SW-1:0]      head_in [LANES];
   logic [SW-1:0]      tail_ff [LANES];
   logic [SW-1:0]      tail_in [LANES];
   logic [LANES-1:0]   busy_lane_ff, busy_lane_in;
   logic [COUNT_W-1:0] queued_ff, queued_in;
   logic [COUNT_W-1:0] active_ff, active_in;
   logic [LW-1:0]      sel_ff, sel_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               fs_en, fs_we;
   logic [SW-1:0]      fs_addr, fs_wdata, fs_rdata;
   logic               fn_en, fn_we;
   logic [SW-1:0]      fn_addr;
   logic [63:0]        fn_rdata, arg_rdata;
   logic               nx_en, nx_we;
   logic [SW-1:0]      nx_addr, nx_wdata, nx_rdata;

   logic [SW:0]        reset_entry;
   logic [SW-1:0]      pop_slot;
   logic [SW-1:0]      deq_slot;
   logic [LW-1:0]      enq_lane;
   logic [SW:0]        depth_dec;

   assign depth_dec   = depth_ff - 1'b1;
   assign reset_entry = POOL_N - depth_ff;
   assign pop_slot    = (depth_ff == low_ff) ? reset_entry[SW-1:0] : fs_rdata;
   assign enq_lane    = LW'(cmd_ff.lane);
   assign deq_slot    = head_ff[sel_ff];

   pmq_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_free_stack (
      .clock(clock), .en(fs_en), .we(fs_we), .addr(fs_addr),
      .wdata(fs_wdata), .rdata(fs_rdata)
   );
   pmq_ram #(.WIDTH(64), .DEPTH(POOL_SLOTS)) u_function_store (
      .clock(clock), .en(fn_en), .we(fn_we), .addr(fn_addr),
      .wdata(cmd_ff.job_function), .rdata(fn_rdata)
   );
   pmq_ram #(.WIDTH(64), .DEPTH(POOL_SLOTS)) u_argument_store (
      .clock(clock), .en(fn_en), .we(fn_we), .addr(fn_addr),
      .wdata(cmd_ff.job_argument), .rdata(arg_rdata)
   );
   pmq_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_next_link (
      .clock(clock), .en(nx_en), .we(nx_we), .addr(nx_addr),
      .wdata(nx_wdata), .rdata(nx_rdata)
   );

   always_comb begin
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      depth_in     = depth_ff;
      low_in       = low_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      busy_lane_in = busy_lane_ff;
      queued_in    = queued_ff;
      active_in    = active_ff;
      sel_in       = sel_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      fs_en        = 1'b0;
      fs_we        = 1'b0;
      fs_addr      = depth_dec[SW-1:0];
      fs_wdata     = SW'(cmd_ff.slot);
      fn_en        = 1'b0;
      fn_we        = 1'b0;
      fn_addr      = '0;
      nx_en        = 1'b0;
      nx_we        = 1'b0;
      nx_addr      = '0;
      nx_wdata     = pop_slot;

      case (phase_ff)
         PH_ISSUE: begin
            if (cmd_valid) begin
               pop      = 1'b1;
               cmd_in   = cmd;
               phase_in = PH_FINISH;
               sel_in   = '0;
               found_in = 1'b0;
               for (int i = LANES - 1; i >= 0; i--) begin
                  if (busy_lane_ff[i]) begin
                     sel_in   = LW'(i);
                     found_in = 1'b1;
                  end
               end
               fs_en   = 1'b1;
               fs_addr = depth_dec[SW-1:0];
               fn_en   = 1'b1;
               fn_addr = head_ff[sel_in];
               nx_en   = 1'b1;
               nx_addr = head_ff[sel_in];
            end
         end
         PH_FINISH: begin
            phase_in              = PH_ISSUE;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_BAD;
            rsp_in.out_function   = '0;
            rsp_in.out_argument   = '0;
            rsp_in.out_slot       = '0;
            case (cmd_ff.kind)
               CMD_ENQ: begin
                  if (depth_ff == '0) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     depth_in = depth_dec;
                     low_in   = (depth_dec < low_ff) ? depth_dec : low_ff;
                     fn_en    = 1'b1;
                     fn_we    = 1'b1;
                     fn_addr  = pop_slot;
                     if (busy_lane_ff[enq_lane]) begin
                        nx_en   = 1'b1;
                        nx_we   = 1'b1;
                        nx_addr = tail_ff[enq_lane];
                     end else begin
                        head_in[enq_lane]      = pop_slot;
                        busy_lane_in[enq_lane] = 1'b1;
                     end
                     tail_in[enq_lane] = pop_slot;
                     queued_in = (queued_ff == COUNT_W'(COUNT_MAX)) ? queued_ff
                                                                    : queued_ff + 1'b1;
                     rsp_in.status   = ST_OK;
                     rsp_in.out_slot = 12'(pop_slot);
                  end
               end
               CMD_DEQ: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     if (deq_slot == tail_ff[sel_ff]) begin
                        busy_lane_in[sel_ff] = 1'b0;
                     end else begin
                        head_in[sel_ff] = nx_rdata;
                     end
                     queued_in = (queued_ff == '0) ? queued_ff : queued_ff - 1'b1;
                     active_in = (active_ff == COUNT_W'(COUNT_MAX)) ? active_ff
                                                                    : active_ff + 1'b1;
                     rsp_in.status       = ST_OK;
                     rsp_in.out_function = fn_rdata;
                     rsp_in.out_argument = arg_rdata;
                     rsp_in.out_slot     = 12'(deq_slot);
                  end
               end
               CMD_REL: begin
                  if (depth_ff < POOL_N) begin
                     fs_en    = 1'b1;
                     fs_we    = 1'b1;
                     fs_addr  = depth_ff[SW-1:0];
                     depth_in = depth_ff + 1'b1;
                     active_in = (active_ff == '0) ? active_ff : active_ff - 1'b1;
                     rsp_in.status = ST_OK;
                  end
               end
               default: begin
                  rsp_in.status = ST_BAD;
               end
            endcase
            rsp_in.queued_count = queued_in;
            rsp_in.active_count = active_in;
            rsp_in.drained      = (queued_in == '0) && (active_in == '0);
         end
         default: begin
            phase_in = PH_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ISSUE;
         depth_ff     <= POOL_N;
         low_ff       <= POOL_N;
         busy_lane_ff <= '0;
         queued_ff    <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         low_ff       <= low_in;
         busy_lane_ff <= busy_lane_in;
         queued_ff    <= queued_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      cmd_ff   <= cmd_in;
      sel_ff   <= sel_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(phase_ff == PH_FINISH))
      else $error("response without finish phase");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= POOL_N)
      else $error("free depth beyond pool");
   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      low_ff <= depth_ff)
      else $error("low-water mark above free depth");
   a_pop_on_issue: assert property (@(posedge clock) disable iff (reset)
      pop |=> phase_ff == PH_FINISH)
      else $error("request taken without finish phase");
`endif
endmodule
`default_nettype wire

>>> rtl/priority_multi_queue_with_free_list_unit.sv
// A request accepted with the command queue empty is written to the queue, taken in the
// back end's issue phase and registered as a result in its finish phase; the receiver
// cannot hold it off. The back end takes a new request only after finishing the last one,
// set by the read-then-write pass over its single-port slot, link and free-stack memories.
// Two requests can wait in the command queue; busy rises when it is full.
// Reset: synchronous; no memory clearing pass, free stack served by a low mark.
`default_nettype none
module priority_multi_queue_with_free_list_unit #(
   parameter int unsigned POOL_SLOTS = 4096,
   parameter int unsigned LANES      = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pmq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pmq_pkg::rsp_type      rsp_data
);
   import pmq_pkg::*;

   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign busy = full;

   pmq_front #(.POOL_SLOTS(POOL_SLOTS), .LANES(LANES)) u_front (
      .start(start), .full(full), .req_data(req_data), .push(push), .cmd(push_cmd)
   );

   pmq_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd), .pop(pop),
      .full(full), .not_empty(not_empty), .head_cmd(head_cmd)
   );

   pmq_back #(.POOL_SLOTS(POOL_SLOTS), .LANES(LANES)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(not_empty), .cmd(head_cmd), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pmq_pkg::*;

   localparam int unsigned SLOTS = 4096;
   localparam int unsigned NLANES = 4;
   localparam int unsigned STALL_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   priority_multi_queue_with_free_list_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // job queue mirror
   logic [63:0] jq_function [SLOTS];
   logic [63:0] jq_argument [SLOTS];
   logic [11:0] jq_link [SLOTS];
   logic [11:0] jq_free [SLOTS];
   int unsigned jq_free_depth;
   logic [11:0] jq_head [NLANES];
   logic [11:0] jq_tail [NLANES];
   bit          jq_busy_lane [NLANES];
   int unsigned jq_queued;
   int unsigned jq_active;

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   int unsigned send_idle_pct;
   int unsigned mismatches;
   int unsigned stall_cycles;
   bit          finished;

   logic [11:0] slots_out[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type job_queue_step(req_type r);
      rsp_type o;
      logic [11:0] s;
      o = '0;
      o.status = ST_BAD;
      case (r.opcode)
         OP_ENQUEUE: begin
            if (r.job_function == 64'd0 || r.priority_req >= NLANES) begin
               o.status = ST_BAD;
            end else if (jq_free_depth == 0) begin
               o.status = ST_FULL;
            end else begin
               jq_free_depth--;
               s = jq_free[jq_free_depth];
               jq_function[s] = r.job_function;
               jq_argument[s] = r.job_argument;
               if (jq_busy_lane[r.priority_req]) begin
                  jq_link[jq_tail[r.priority_req]] = s;
                  jq_tail[r.priority_req] = s;
               end else begin
                  jq_head[r.priority_req] = s;
                  jq_tail[r.priority_req] = s;
                  jq_busy_lane[r.priority_req] = 1'b1;
               end
               if (jq_queued < COUNT_MAX) jq_queued++;
               o.status = ST_OK;
               o.out_slot = s;
            end
         end
         OP_DEQUEUE: begin
            o.status = ST_EMPTY;
            for (int p = 0; p < NLANES; p++) begin
               if (jq_busy_lane[p]) begin
                  s = jq_head[p];
                  if (s == jq_tail[p]) jq_busy_lane[p] = 1'b0;
                  else jq_head[p] = jq_link[s];
                  if (jq_queued > 0) jq_queued--;
                  if (jq_active < COUNT_MAX) jq_active++;
                  o.out_function = jq_function[s];
                  o.out_argument = jq_argument[s];
                  o.out_slot = s;
                  o.status = ST_OK;
                  break;
               end
            end
         end
         OP_RELEASE: begin
            if (jq_free_depth < SLOTS) begin
               jq_free[jq_free_depth] = r.slot;
               jq_free_depth++;
               if (jq_active > 0) jq_active--;
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      o.queued_count = jq_queued[12:0];
      o.active_count = jq_active[12:0];
      o.drained = (jq_queued == 0 && jq_active == 0);
      return o;
   endfunction

   function automatic req_type make_req(opcode_type op, logic [63:0] fn, logic [63:0] arg,
                                        logic [2:0] lane, logic [11:0] slot);
      req_type r;
      r.opcode = op;
      r.job_function = fn;
      r.job_argument = arg;
      r.priority_req = lane;
      r.slot = slot;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic push_req(req_type r);
      pending_reqs.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            e = job_queue_step(req_data);
            expected_rsps.push_back(e);
         end
         if (!(start && busy)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (!reset && !finished && stall_cycles >= STALL_LIMIT) begin
         $display("** priority_multi_queue_with_free_list_unit: FAILED **");
         $finish;
      end
   end

   // shadow of the free stack and lanes, to learn dequeued slots ahead of time
   logic [11:0] sh_free [SLOTS];
   int unsigned sh_depth;
   logic [11:0] sh_order [NLANES][$];

   task automatic gen(opcode_type op, logic [63:0] fn, logic [2:0] lane, logic [11:0] slot);
      case (op)
         OP_ENQUEUE: begin
            push_req(make_req(op, fn, rand64(), lane, slot));
            if (fn != 0 && lane < NLANES && sh_depth > 0) begin
               sh_depth--;
               sh_order[lane].push_back(sh_free[sh_depth]);
            end
         end
         OP_DEQUEUE: begin
            push_req(make_req(op, rand64(), rand64(), lane, slot));
            for (int p = 0; p < NLANES; p++) begin
               if (sh_order[p].size() != 0) begin
                  slots_out.push_back(sh_order[p].pop_front());
                  break;
               end
            end
         end
         OP_RELEASE: begin
            push_req(make_req(op, rand64(), rand64(), lane, slot));
            if (sh_depth < SLOTS) begin
               sh_free[sh_depth] = slot;
               sh_depth++;
            end
         end
         default: push_req(make_req(op, fn, rand64(), lane, slot));
      endcase
   endtask

   task automatic gen_release();
      int idx;
      if (slots_out.size() == 0) begin
         gen(OP_DEQUEUE, 0, 0, 0);
         return;
      end
      idx = $urandom_range(slots_out.size() - 1);
      gen(OP_RELEASE, 0, 3'($urandom()), slots_out[idx]);
      slots_out.delete(idx);
   endtask

   task automatic gen_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) gen(OP_ENQUEUE, rand64() | 64'd1, 3'($urandom_range(NLANES - 1)), 12'($urandom()));
         else if (k < 75) gen(OP_DEQUEUE, 0, 3'($urandom()), 12'($urandom()));
         else if (k < 92) gen_release();
         else if (k < 95) gen(OP_ENQUEUE, 64'd0, 3'($urandom()), 12'($urandom()));
         else if (k < 97) gen(OP_ENQUEUE, rand64() | 64'd1, 3'($urandom_range(7, NLANES)), 0);
         else gen(OP_UNUSED, rand64(), 3'($urandom()), 12'($urandom()));
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      mismatches = 0;
      finished = 1'b0;
      send_idle_pct = 6;
      jq_free_depth = SLOTS;
      sh_depth = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
         jq_free[i] = 12'(SLOTS - 1 - i);
         sh_free[i] = 12'(SLOTS - 1 - i);
      end
      for (int p = 0; p < NLANES; p++) begin
         jq_head[p] = '0;
         jq_tail[p] = '0;
         jq_busy_lane[p] = 1'b0;
      end
      jq_queued = 0;
      jq_active = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      gen(OP_DEQUEUE, 0, 0, 0);
      gen(OP_RELEASE, 0, 7, 12'hfff);
      gen(OP_ENQUEUE, '1, 3, 12'hfff);
      gen(OP_ENQUEUE, 64'd1, 0, 0);
      gen(OP_ENQUEUE, 64'd0, 0, 0);
      gen(OP_ENQUEUE, 64'h8000_0000_0000_0000, 4, 0);
      gen(OP_ENQUEUE, 64'h5a5a, 7, 0);
      gen(OP_ENQUEUE, rand64() | 1, 2, 0);
      gen(OP_ENQUEUE, rand64() | 1, 1, 0);
      gen(OP_ENQUEUE, rand64() | 1, 0, 0);
      gen(OP_UNUSED, '1, 7, 12'hfff);
      for (int i = 0; i < 6; i++) gen(OP_DEQUEUE, 0, 0, 0);
      for (int i = 0; i < 5; i++) gen_release();
      gen(OP_RELEASE, 0, 0, 12'd0);
      gen_random(350);
      wait_drained();
      send_idle_pct = 75;
      gen_random(350);
      wait_drained();
      send_idle_pct = 0;
      gen_random(400);
      wait_drained();
      repeat (10) @(posedge clock);
      finished = 1'b1;
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("** priority_multi_queue_with_free_list_unit: PASSED **");
      else
         $display("** priority_multi_queue_with_free_list_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
